/* design/mpq_pkg.sv */
// Shared constants, codes and control types for the multilevel priority ready deque.
`timescale 1ns / 1ps
`default_nettype none
package mpq_pkg;

  // Default sizing handed to the top level.
  localparam int LEVELS_DEF      = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TASK_BITS_DEF   = 8;

  // Beat field widths, fixed by the stream format.
  localparam int OPCODE_W  = 2;
  localparam int LEVEL_W   = 2;
  localparam int TASK_ID_W = 8;
  localparam int POPPED_W  = 8;
  localparam int STATUS_W  = 2;
  localparam int MASK_W    = 4;

  // Input beat layout, lowest bit first, padded to whole bytes.
  localparam int IN_OPCODE_LSB = 0;
  localparam int IN_LEVEL_LSB  = IN_OPCODE_LSB + OPCODE_W;
  localparam int IN_TASK_LSB   = IN_LEVEL_LSB + LEVEL_W;
  localparam int IN_BITS       = IN_TASK_LSB + TASK_ID_W;
  localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

  // Output beat layout, lowest bit first, padded to whole bytes.
  localparam int OUT_POPPED_LSB = 0;
  localparam int OUT_STATUS_LSB = OUT_POPPED_LSB + POPPED_W;
  localparam int OUT_MASK_LSB   = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_BITS       = OUT_MASK_LSB + MASK_W;
  localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_POP        = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input beat
    logic exec;    // update pointers and access the entry store
    logic finish;  // load the result register
  } mpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // result register holds a beat that is not taken this cycle
  } mpq_stat_t;

endpackage
`default_nettype wire

/* design/mpq_ctrl.sv */
// Controller state machine sequencing each operation through execute and finish.
`timescale 1ns / 1ps
`default_nettype none
module mpq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire mpq_pkg::mpq_stat_t stat,
  output mpq_pkg::mpq_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        // No beat is taken while reset is held, since it would be lost.
        if (!rst) begin
          s_tready = 1'b1;
          if (s_tvalid) begin
            cmd.load   = 1'b1;
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        // Execute only once the result register is sure to be free at finish.
        if (!stat.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/mpq_datapath.sv */
// Datapath: item register, per-level head and count registers, entry store, result register.
`timescale 1ns / 1ps
`default_nettype none
module mpq_datapath #(
  parameter int LEVELS      = mpq_pkg::LEVELS_DEF,
  parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_BITS   = mpq_pkg::TASK_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire mpq_pkg::mpq_cmd_t               cmd,
  output mpq_pkg::mpq_stat_t                   stat,
  input  wire logic [mpq_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [mpq_pkg::OUT_TDATA_W-1:0]      m_tdata
);

  localparam int LVL_W   = $clog2(LEVELS);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int ENTRIES = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);

  // Captured input item.
  logic [mpq_pkg::OPCODE_W-1:0] op;
  logic [mpq_pkg::LEVEL_W-1:0]  lvl;
  logic [TASK_BITS-1:0]         task_val;

  // Per-level queue state.
  logic [PTR_W-1:0] head [LEVELS];
  logic [CNT_W-1:0] occ  [LEVELS];

  // Entry store and its registered read data.
  logic [TASK_BITS-1:0] mem [ENTRIES];
  logic [TASK_BITS-1:0] rdata;

  // Outcome of the execute step.
  logic [mpq_pkg::STATUS_W-1:0] status_q;
  logic                         pop_ok_q;

  // Result register.
  logic [mpq_pkg::POPPED_W-1:0] out_popped;
  logic [mpq_pkg::STATUS_W-1:0] out_status;
  logic [mpq_pkg::MASK_W-1:0]   out_mask;

  logic [LVL_W-1:0]             li;
  logic                         lvl_ok;
  logic [PTR_W-1:0]             cur_head;
  logic [CNT_W-1:0]             cur_occ;
  logic                         is_push;
  logic                         is_pop;
  logic                         push_ok;
  logic                         pop_ok;
  logic [SUM_W-1:0]             back_sum;
  logic [PTR_W-1:0]             back_pos;
  logic [PTR_W-1:0]             front_pos;
  logic [PTR_W-1:0]             head_inc;
  logic [PTR_W-1:0]             pos;
  logic [ADDR_W-1:0]            addr;
  logic [mpq_pkg::STATUS_W-1:0] status_next;
  logic [mpq_pkg::MASK_W-1:0]   mask_now;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= s_tdata[mpq_pkg::IN_OPCODE_LSB +: mpq_pkg::OPCODE_W];
      lvl      <= s_tdata[mpq_pkg::IN_LEVEL_LSB +: mpq_pkg::LEVEL_W];
      task_val <= TASK_BITS'(s_tdata[mpq_pkg::IN_TASK_LSB +: mpq_pkg::TASK_ID_W]);
    end
  end

  assign li       = LVL_W'(lvl);
  assign lvl_ok   = (32'(lvl) < 32'(LEVELS));
  assign cur_head = head[li];
  assign cur_occ  = occ[li];

  assign is_push = (op == mpq_pkg::OP_PUSH_BACK) || (op == mpq_pkg::OP_PUSH_FRONT);
  assign is_pop  = (op == mpq_pkg::OP_POP);
  assign push_ok = is_push && lvl_ok && (cur_occ != CNT_W'(QUEUE_DEPTH));
  assign pop_ok  = is_pop && lvl_ok && (cur_occ != '0);

  // Head plus count stays below twice the depth, so one subtract wraps it.
  assign back_sum = SUM_W'(cur_head) + SUM_W'(cur_occ);
  assign back_pos = (back_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    PTR_W'(back_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(back_sum);
  assign front_pos = (cur_head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : (cur_head - PTR_W'(1));
  assign head_inc  = (cur_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (cur_head + PTR_W'(1));

  always_comb begin
    case (op)
      mpq_pkg::OP_PUSH_BACK:  pos = back_pos;
      mpq_pkg::OP_PUSH_FRONT: pos = front_pos;
      default:                pos = cur_head;
    endcase
  end

  assign addr = ADDR_W'(32'(li) * QUEUE_DEPTH + 32'(pos));

  always_comb begin
    status_next = mpq_pkg::ST_DONE;
    if (is_push && !push_ok) begin
      status_next = mpq_pkg::ST_FULL;
    end else if (is_pop && !pop_ok) begin
      status_next = mpq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q <= status_next;
      pop_ok_q <= pop_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      mem[addr] <= task_val;
    end
    if (cmd.exec) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        occ[i]  <= '0;
      end
    end else if (cmd.exec) begin
      if (push_ok) begin
        occ[li] <= cur_occ + CNT_W'(1);
        if (op == mpq_pkg::OP_PUSH_FRONT) begin
          head[li] <= front_pos;
        end
      end else if (pop_ok) begin
        occ[li]  <= cur_occ - CNT_W'(1);
        head[li] <= head_inc;
      end
    end
  end

  // Only the four lowest levels are reported.
  for (genvar g = 0; g < mpq_pkg::MASK_W; g++) begin : g_mask
    if (g < LEVELS) begin : g_lvl
      assign mask_now[g] = (occ[g] != '0);
    end else begin : g_none
      assign mask_now[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_popped <= pop_ok_q ? mpq_pkg::POPPED_W'(rdata) : '0;
      out_status <= status_q;
      out_mask   <= mask_now;
    end
  end

  assign stat.out_busy = m_tvalid && !m_tready;

  always_comb begin
    m_tdata = '0;
    m_tdata[mpq_pkg::OUT_POPPED_LSB +: mpq_pkg::POPPED_W] = out_popped;
    m_tdata[mpq_pkg::OUT_STATUS_LSB +: mpq_pkg::STATUS_W] = out_status;
    m_tdata[mpq_pkg::OUT_MASK_LSB +: mpq_pkg::MASK_W]     = out_mask;
  end

endmodule
`default_nettype wire

/* design/multi_priority_ready_deque_unit.sv */
// Top level of the multilevel priority ready deque: controller plus datapath.
//
//   Channel | Direction | Handshake          | Beat contents
//   s_*     | in        | s_tvalid/s_tready  | opcode, level, task_id
//   m_*     | out       | m_tvalid/m_tready  | popped_task, status, nonempty_mask
//
// Each operation passes through accept, execute (one access to the
// single-port entry store plus head and count update), and loading the result.
// A new beat is accepted while the previous result still waits on m_tready.
// Execution waits while an untaken result occupies the output register.
// Synchronous reset empties every level; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module multi_priority_ready_deque_unit #(
  parameter int LEVELS      = mpq_pkg::LEVELS_DEF,
  parameter int QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_BITS   = mpq_pkg::TASK_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // opcode[1:0], level[3:2], task_id[11:4], zero pad above
  input  wire logic [mpq_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // popped_task[7:0], status[9:8], nonempty_mask[13:10], zero pad above
  output logic [mpq_pkg::OUT_TDATA_W-1:0]      m_tdata
);

  mpq_pkg::mpq_cmd_t  cmd;
  mpq_pkg::mpq_stat_t stat;

  mpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpq_datapath #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_BITS   (TASK_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

/* verif/tb_multi_priority_ready_deque_unit.sv */
// Self-checking testbench for the multilevel priority ready deque unit.
`timescale 1ns / 1ps
module tb_multi_priority_ready_deque_unit;
  import mpq_pkg::*;

  localparam int NUM_LEVELS  = LEVELS_DEF;
  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int RANDOM_OPS  = 1650;
  localparam int SETTLE_CYC  = 12;

  // The block treats the fourth opcode as a no-op that still answers.
  localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [POPPED_W-1:0] popped;
    logic [STATUS_W-1:0] status;
    logic [MASK_W-1:0]   mask;
  } deque_result_t;

  // One directed beat; when pinned is set the answer is written down by hand.
  typedef struct {
    logic [OPCODE_W-1:0]  op;
    logic [LEVEL_W-1:0]   lv;
    logic [TASK_ID_W-1:0] task_id;
    bit                   pinned;
    deque_result_t        answer;
  } beat_plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Shadow copy of the ready queues.
  logic [TASK_ID_W-1:0] shadow_slots [NUM_LEVELS][DEPTH];
  int unsigned          shadow_head  [NUM_LEVELS];
  int unsigned          shadow_fill  [NUM_LEVELS];

  deque_result_t pending_results[$];
  beat_plan_t    sent_plans[$];
  beat_plan_t    directed_rows[$];

  int errors     = 0;
  int n_results  = 0;
  int n_popped   = 0;
  int n_empty    = 0;
  int n_full     = 0;
  int sender_idle_pct = 0;
  int stall_pct       = 0;

  multi_priority_ready_deque_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Applies one operation to the shadow queues and returns the answer it gives.
  function automatic deque_result_t deque_apply(logic [OPCODE_W-1:0] op,
                                                logic [LEVEL_W-1:0] lv,
                                                logic [TASK_ID_W-1:0] task_id);
    deque_result_t r;
    int unsigned slot;
    r = '0;
    r.status = ST_DONE;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (shadow_fill[lv] >= DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_BACK) begin
          slot = (shadow_head[lv] + shadow_fill[lv]) % DEPTH;
          shadow_slots[lv][slot] = task_id;
          shadow_fill[lv]++;
        end else begin
          slot = (shadow_head[lv] + DEPTH - 1) % DEPTH;
          shadow_slots[lv][slot] = task_id;
          shadow_head[lv] = slot;
          shadow_fill[lv]++;
        end
      end
      OP_POP: begin
        if (shadow_fill[lv] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = shadow_slots[lv][shadow_head[lv]];
          shadow_head[lv] = (shadow_head[lv] + 1) % DEPTH;
          shadow_fill[lv]--;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_LEVELS; i++) r.mask[i] = (shadow_fill[i] != 0);
    return r;
  endfunction

  function automatic deque_result_t make_answer(logic [POPPED_W-1:0] popped,
                                                logic [STATUS_W-1:0] status,
                                                logic [MASK_W-1:0] mask);
    deque_result_t r;
    r.popped = popped;
    r.status = status;
    r.mask   = mask;
    return r;
  endfunction

  function automatic void add_row(logic [OPCODE_W-1:0] op, logic [LEVEL_W-1:0] lv,
                                  logic [TASK_ID_W-1:0] task_id, bit pinned,
                                  deque_result_t answer);
    beat_plan_t p;
    p.op = op;
    p.lv = lv;
    p.task_id = task_id;
    p.pinned = pinned;
    p.answer = answer;
    directed_rows.push_back(p);
  endfunction

  task automatic send_beat(beat_plan_t p);
    @(negedge clk);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    sent_plans.push_back(p);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({p.task_id, p.lv, p.op});
    do @(posedge clk); while (!s_tready);
  endtask

  // Bursts lean toward pushing, popping or neither, and toward one level, so queues
  // both fill up and drain out often.
  task automatic run_random(int count);
    beat_plan_t p;
    int done_ops;
    int burst_left;
    int push_pct;
    int focus_lv;
    done_ops = 0;
    burst_left = 0;
    push_pct = 50;
    focus_lv = 0;
    p.pinned = 1'b0;
    p.answer = '0;
    while (done_ops < count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(60, 20);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
        focus_lv = $urandom_range(NUM_LEVELS - 1);
      end
      burst_left--;
      p.lv = ($urandom_range(99) < 70) ? focus_lv[LEVEL_W-1:0] : LEVEL_W'($urandom);
      p.task_id = TASK_ID_W'($urandom);
      if ($urandom_range(99) < 3) begin
        p.op = OP_NONE;
      end else if ($urandom_range(99) < push_pct) begin
        p.op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        done_ops++;
      end else begin
        p.op = OP_POP;
        done_ops++;
      end
      send_beat(p);
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    beat_plan_t p;
    deque_result_t predicted;
    deque_result_t want;
    deque_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        p = sent_plans.pop_front();
        predicted = deque_apply(s_tdata[IN_OPCODE_LSB +: OPCODE_W],
                                s_tdata[IN_LEVEL_LSB +: LEVEL_W],
                                s_tdata[IN_TASK_LSB +: TASK_ID_W]);
        pending_results.push_back(p.pinned ? p.answer : predicted);
      end
      if (m_tvalid && m_tready) begin
        got.popped = m_tdata[OUT_POPPED_LSB +: POPPED_W];
        got.status = m_tdata[OUT_STATUS_LSB +: STATUS_W];
        got.mask   = m_tdata[OUT_MASK_LSB +: MASK_W];
        n_results++;
        if (got.status == ST_EMPTY) n_empty++;
        if (got.status == ST_FULL) n_full++;
        if (got.status == ST_DONE && got.popped != 0) n_popped++;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: popped %0h status %0d mask %b",
                   $time, got.popped, got.status, got.mask);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.popped !== want.popped) begin
            $display("%0t: popped_task expected %0h actual %0h", $time, want.popped, got.popped);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.mask !== want.mask) begin
            $display("%0t: nonempty_mask expected %b actual %b", $time, want.mask, got.mask);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int senders [4];
    int stalls  [4];
    senders = '{0, 77, 0, 16};
    stalls  = '{0, 0, 77, 16};
    for (int i = 0; i < NUM_LEVELS; i++) begin
      shadow_head[i] = 0;
      shadow_fill[i] = 0;
    end

    // Empty queues answer pops with the empty status; the no-op still answers.
    add_row(OP_POP, 0, 8'h00, 1'b1, make_answer(8'h00, ST_EMPTY, 4'b0000));
    add_row(OP_NONE, 1, 8'hA5, 1'b1, make_answer(8'h00, ST_DONE, 4'b0000));
    add_row(OP_PUSH_BACK, 0, 8'hFF, 1'b1, make_answer(8'h00, ST_DONE, 4'b0001));
    add_row(OP_PUSH_FRONT, 0, 8'h00, 1'b0, '0);
    add_row(OP_PUSH_BACK, 3, 8'h5A, 1'b0, '0);
    add_row(OP_POP, 0, 8'h33, 1'b0, '0);
    add_row(OP_POP, 0, 8'hCC, 1'b0, '0);
    add_row(OP_POP, 3, 8'h00, 1'b0, '0);
    // Fill level 1 from both ends so the head wraps, then overflow it.
    for (int i = 0; i < DEPTH; i++) begin
      add_row(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, 1, TASK_ID_W'(8'h10 + i * 13), 1'b0, '0);
    end
    add_row(OP_PUSH_FRONT, 1, 8'hEE, 1'b1, make_answer(8'h00, ST_FULL, 4'b0010));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_beat(directed_rows[i]);
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = senders[ph];
      stall_pct = stalls[ph];
      run_random(RANDOM_OPS / 4);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    stall_pct = 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Ran %0d directed and about %0d random deque operations over four handshake mixes.",
             directed_rows.size(), RANDOM_OPS);
    $display("Checked %0d results: %0d pops with data, %0d empty pops, %0d dropped pushes.",
             n_results, n_popped, n_empty, n_full);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout: %0d results still outstanding.", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
